/* hdl/qlrs_pkg.sv */
// qlrs_pkg: widths, codes and pipeline side-band types for the root solver.
// No dependencies; every other file refers to it by scoped names.
package qlrs_pkg;

    localparam int W     = 32;          // coefficient and root word
    localparam int F     = 16;          // fraction bits
    localparam int TOL_W = 16;          // tolerance register width
    localparam int SW    = W + 1;       // square root width
    localparam int DW2   = 2 * SW;      // discriminant width fed to the root unit
    localparam int NW    = W + 2;       // numerator magnitude width
    localparam int QW    = NW + F;      // quotient width
    localparam int DVW   = W + 1;       // divisor width
    localparam int RW    = DVW;         // divider remainder width

    localparam logic [W-1:0] HALF_MAG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_TOL  = 1'b1;
    localparam logic MODE_LIN = 1'b0;
    localparam logic MODE_QUAD = 1'b1;

    typedef enum logic [2:0] {
        ST_NONE = 3'd0,
        ST_ONE  = 3'd1,
        ST_TWO  = 3'd2,
        ST_ALL  = 3'd3,
        ST_NOTQ = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic [W-1:0]        am;
        logic [W-1:0]        bm;
        logic                an;
        logic                bn;
        logic                lin;
        logic                az;
        logic                bz;
        logic                cz;
        logic                dneg;
        logic                dzero;
    } side_t;

    typedef struct packed {
        status_t status;
        logic    go;
        logic    neg1;
        logic    neg2;
    } dside_t;

endpackage

/* hdl/qlrs_front.sv */
// qlrs_front: decode, products and exact discriminant (three register stages).
// Depends on qlrs_pkg.
module qlrs_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic signed [qlrs_pkg::W-1:0] coef_a,
    input  logic signed [qlrs_pkg::W-1:0] coef_b,
    input  logic signed [qlrs_pkg::W-1:0] coef_c,
    input  logic                         mode,
    input  logic [qlrs_pkg::TOL_W-1:0]   tol,
    output logic                         out_vld,
    output logic [qlrs_pkg::DW2-1:0]     d_mag,
    output qlrs_pkg::side_t              side_out
);

    localparam int W = qlrs_pkg::W;
    localparam int DX = 2 * W + 3;

    logic [W-1:0] ua, ub, uc, am, bm, cm, tol_x;
    qlrs_pkg::side_t side1_next, side1_reg, side2_reg, side3_next, side3_reg;
    logic signed [W-1:0] a1_reg;
    logic signed [W-1:0] b1, c1;
    logic signed [2*W-1:0] bb_next, ac_next, bb2_reg, ac2_reg;
    logic signed [DX-1:0] d;
    logic [qlrs_pkg::DW2-1:0] d3_next, d3_reg;
    logic v1_reg, v2_reg, v3_reg;

    assign ua = coef_a;
    assign ub = coef_b;
    assign uc = coef_c;
    assign am = ua[W-1] ? (~ua + 1'b1) : ua;
    assign bm = ub[W-1] ? (~ub + 1'b1) : ub;
    assign cm = uc[W-1] ? (~uc + 1'b1) : uc;
    assign tol_x = W'(tol);

    always_comb
    begin
        side1_next.b     = coef_b;
        side1_next.c     = coef_c;
        side1_next.am    = am;
        side1_next.bm    = bm;
        side1_next.an    = ua[W-1];
        side1_next.bn    = ub[W-1];
        side1_next.lin   = (mode == qlrs_pkg::MODE_LIN);
        side1_next.az    = (am <= tol_x);
        side1_next.bz    = (bm <= tol_x);
        side1_next.cz    = (cm <= tol_x);
        side1_next.dneg  = 1'b0;
        side1_next.dzero = 1'b0;
    end

    assign b1 = side1_reg.b;
    assign c1 = side1_reg.c;
    assign bb_next = b1 * b1;
    assign ac_next = a1_reg * c1;

    // D = B*B - 4*A*C, exact
    assign d = DX'(bb2_reg) - (DX'(ac2_reg) <<< 2);

    always_comb
    begin
        side3_next       = side2_reg;
        side3_next.dneg  = d[DX-1];
        side3_next.dzero = (d == '0);
        d3_next          = d[DX-1] ? '0 : d[qlrs_pkg::DW2-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= coef_a;
            side1_reg <= side1_next;
            bb2_reg   <= bb_next;
            ac2_reg   <= ac_next;
            side2_reg <= side1_reg;
            d3_reg    <= d3_next;
            side3_reg <= side3_next;
        end
    end

    assign out_vld  = v3_reg;
    assign d_mag    = d3_reg;
    assign side_out = side3_reg;

endmodule

/* hdl/qlrs_sqrt.sv */
// qlrs_sqrt: pipelined integer square root, one root bit per register stage.
// Depends on qlrs_pkg.
module qlrs_sqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [qlrs_pkg::DW2-1:0]  d_in,
    input  qlrs_pkg::side_t           side_in,
    output logic                      out_vld,
    output logic [qlrs_pkg::SW-1:0]   root,
    output qlrs_pkg::side_t           side_out
);

    localparam int SW  = qlrs_pkg::SW;
    localparam int DW2 = qlrs_pkg::DW2;
    localparam int RMW = SW + 2;

    logic [RMW-1:0]  rem_reg [SW];
    logic [RMW-1:0]  rem_next [SW];
    logic [SW-1:0]   rt_reg [SW];
    logic [SW-1:0]   rt_next [SW];
    logic [DW2-1:0]  dd_reg [SW];
    logic [DW2-1:0]  dd_next [SW];
    qlrs_pkg::side_t sd_reg [SW];
    qlrs_pkg::side_t sd_next [SW];
    logic [SW-1:0]   vld_reg;

    always_comb
    begin
        logic [RMW-1:0] r_in;
        logic [SW-1:0]  q_in;
        logic [DW2-1:0] d_cur;
        logic [RMW+1:0] t;
        logic [RMW+1:0] trial;
        for (int k = 0; k < SW; k++)
        begin
            if (k == 0)
            begin
                r_in       = '0;
                q_in       = '0;
                d_cur      = d_in;
                sd_next[k] = side_in;
            end
            else
            begin
                r_in       = rem_reg[k-1];
                q_in       = rt_reg[k-1];
                d_cur      = dd_reg[k-1];
                sd_next[k] = sd_reg[k-1];
            end
            t     = {r_in, d_cur[DW2-1:DW2-2]};
            trial = {2'b00, q_in, 2'b01};
            if (t >= trial)
            begin
                rem_next[k] = RMW'(t - trial);
                rt_next[k]  = {q_in[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = RMW'(t);
                rt_next[k]  = {q_in[SW-2:0], 1'b0};
            end
            dd_next[k] = d_cur << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SW-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            rt_reg  <= rt_next;
            dd_reg  <= dd_next;
            sd_reg  <= sd_next;
        end
    end

    assign out_vld  = vld_reg[SW-1];
    assign root     = rt_reg[SW-1];
    assign side_out = sd_reg[SW-1];

endmodule

/* hdl/qlrs_div.sv */
// qlrs_div: two-lane pipelined restoring divider sharing one divisor,
// one quotient bit per stage. Depends on qlrs_pkg.
module qlrs_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [qlrs_pkg::NW-1:0]   n1,
    input  logic [qlrs_pkg::NW-1:0]   n2,
    input  logic [qlrs_pkg::DVW-1:0]  den,
    input  qlrs_pkg::dside_t          side_in,
    output logic                      out_vld,
    output logic [qlrs_pkg::QW-1:0]   q1,
    output logic [qlrs_pkg::QW-1:0]   q2,
    output logic [qlrs_pkg::RW-1:0]   r1,
    output logic [qlrs_pkg::RW-1:0]   r2,
    output logic [qlrs_pkg::DVW-1:0]  den_out,
    output qlrs_pkg::dside_t          side_out
);

    localparam int QW  = qlrs_pkg::QW;
    localparam int RW  = qlrs_pkg::RW;
    localparam int DVW = qlrs_pkg::DVW;
    localparam int F   = qlrs_pkg::F;

    logic [RW-1:0]    rm_reg  [QW][2];
    logic [RW-1:0]    rm_next [QW][2];
    logic [QW-1:0]    q_reg   [QW][2];
    logic [QW-1:0]    q_next  [QW][2];
    logic [QW-1:0]    nn_reg  [QW][2];
    logic [QW-1:0]    nn_next [QW][2];
    logic [DVW-1:0]   dv_reg  [QW];
    logic [DVW-1:0]   dv_next [QW];
    qlrs_pkg::dside_t sd_reg  [QW];
    qlrs_pkg::dside_t sd_next [QW];
    logic [QW-1:0]    vld_reg;

    always_comb
    begin
        logic [RW-1:0]  r_in;
        logic [QW-1:0]  q_in;
        logic [QW-1:0]  n_in;
        logic [DVW-1:0] d_cur;
        logic [RW:0]    t;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                d_cur      = den;
                sd_next[k] = side_in;
            end
            else
            begin
                d_cur      = dv_reg[k-1];
                sd_next[k] = sd_reg[k-1];
            end
            dv_next[k] = d_cur;
            for (int l = 0; l < 2; l++)
            begin
                if (k == 0)
                begin
                    r_in = '0;
                    q_in = '0;
                    n_in = (l == 0) ? {n1, {F{1'b0}}} : {n2, {F{1'b0}}};
                end
                else
                begin
                    r_in = rm_reg[k-1][l];
                    q_in = q_reg[k-1][l];
                    n_in = nn_reg[k-1][l];
                end
                t = {r_in, n_in[QW-1]};
                if (t >= {1'b0, d_cur})
                begin
                    rm_next[k][l] = RW'(t - {1'b0, d_cur});
                    q_next[k][l]  = {q_in[QW-2:0], 1'b1};
                end
                else
                begin
                    rm_next[k][l] = RW'(t);
                    q_next[k][l]  = {q_in[QW-2:0], 1'b0};
                end
                nn_next[k][l] = n_in << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QW-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rm_reg <= rm_next;
            q_reg  <= q_next;
            nn_reg <= nn_next;
            dv_reg <= dv_next;
            sd_reg <= sd_next;
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign q1       = q_reg[QW-1][0];
    assign q2       = q_reg[QW-1][1];
    assign r1       = rm_reg[QW-1][0];
    assign r2       = rm_reg[QW-1][1];
    assign den_out  = dv_reg[QW-1];
    assign side_out = sd_reg[QW-1];

endmodule

/* hdl/quadratic_linear_root_solver.sv */
// Channel  | handshake                 | payload
// in       | in_valid / in_ready       | coef_a, coef_b, coef_c (signed Q16.16)
// out      | out_valid / out_ready     | root_status, first_root, second_root, saturated
// cfg      | cfg_wr_en (no wait)       | cfg_index, cfg_data
// One word enters per cycle while out is not stalled; the pipeline depth is set by the
// bit-per-stage square root (33 stages) and divider (50 stages).
// Reset clears valid bits and loads mode = quadratic, tolerance = 0.
// A stall on out freezes every stage at once; in_ready drops the same cycle.
// Top level: front, root and divider pipelines, root selection and rounding.
// Depends on qlrs_pkg, qlrs_front, qlrs_sqrt, qlrs_div.
module quadratic_linear_root_solver
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [qlrs_pkg::W-1:0]   coef_a,
    input  logic signed [qlrs_pkg::W-1:0]   coef_b,
    input  logic signed [qlrs_pkg::W-1:0]   coef_c,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      root_status,
    output logic signed [qlrs_pkg::W-1:0]   first_root,
    output logic signed [qlrs_pkg::W-1:0]   second_root,
    output logic                            saturated,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [qlrs_pkg::TOL_W-1:0]      cfg_data
);

    localparam int W   = qlrs_pkg::W;
    localparam int NW  = qlrs_pkg::NW;
    localparam int QW  = qlrs_pkg::QW;
    localparam int RW  = qlrs_pkg::RW;
    localparam int DVW = qlrs_pkg::DVW;
    localparam int SW  = qlrs_pkg::SW;

    logic                       en;
    logic                       mode_reg;
    logic [qlrs_pkg::TOL_W-1:0] tol_reg;

    logic                       f_vld;
    logic [qlrs_pkg::DW2-1:0]   f_d;
    qlrs_pkg::side_t            f_side;

    logic                       s_vld;
    logic [SW-1:0]              s_root;
    qlrs_pkg::side_t            s_side;

    logic                       v4_reg;
    logic [NW-1:0]              n1_next, n2_next, n1_reg, n2_reg;
    logic [DVW-1:0]             den_next, den_reg;
    qlrs_pkg::dside_t           ds_next, ds_reg;

    logic                       d_vld;
    logic [QW-1:0]              dq [2];
    logic [RW-1:0]              dr [2];
    logic [DVW-1:0]             d_den;
    qlrs_pkg::dside_t           d_side;

    logic                       out_valid_reg;
    qlrs_pkg::status_t          status_next, status_reg;
    logic [W-1:0]               root_next [2];
    logic [W-1:0]               root1_reg, root2_reg;
    logic                       sat_next, sat_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= qlrs_pkg::MODE_QUAD;
            tol_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                qlrs_pkg::REG_MODE: mode_reg <= cfg_data[0];
                qlrs_pkg::REG_TOL:  tol_reg  <= cfg_data;
                default:            mode_reg <= mode_reg;
            endcase
        end
    end

    qlrs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .coef_c   (coef_c),
        .mode     (mode_reg),
        .tol      (tol_reg),
        .out_vld  (f_vld),
        .d_mag    (f_d),
        .side_out (f_side)
    );

    qlrs_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .d_in     (f_d),
        .side_in  (f_side),
        .out_vld  (s_vld),
        .root     (s_root),
        .side_out (s_side)
    );

    // numerators: linear -C, quadratic -B -/+ S; sign and magnitude split
    always_comb
    begin
        logic signed [W-1:0]  b_s, c_s;
        logic signed [NW:0]   bx, cx, sx, v1, v2;
        logic                 dneg;
        b_s = s_side.b;
        c_s = s_side.c;
        bx  = (NW+1)'(b_s);
        cx  = (NW+1)'(c_s);
        sx  = $signed({2'b00, s_root});
        if (s_side.lin)
        begin
            v1       = -cx;
            v2       = -cx;
            den_next = {1'b0, s_side.bm};
            dneg     = s_side.bn;
            if (!s_side.bz)
                status_next = qlrs_pkg::ST_ONE;
            else if (!s_side.cz)
                status_next = qlrs_pkg::ST_NONE;
            else
                status_next = qlrs_pkg::ST_ALL;
        end
        else
        begin
            v1       = -bx - sx;
            v2       = -bx + sx;
            den_next = {s_side.am, 1'b0};
            dneg     = s_side.an;
            if (s_side.az)
                status_next = qlrs_pkg::ST_NOTQ;
            else if (s_side.dneg)
                status_next = qlrs_pkg::ST_NONE;
            else if (s_side.dzero)
                status_next = qlrs_pkg::ST_ONE;
            else
                status_next = qlrs_pkg::ST_TWO;
        end
        n1_next        = v1[NW] ? NW'(-v1) : NW'(v1);
        n2_next        = v2[NW] ? NW'(-v2) : NW'(v2);
        ds_next.status = status_next;
        ds_next.go     = (status_next == qlrs_pkg::ST_ONE) ||
                         (status_next == qlrs_pkg::ST_TWO);
        ds_next.neg1   = v1[NW] ^ dneg;
        ds_next.neg2   = v2[NW] ^ dneg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= s_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= n1_next;
            n2_reg  <= n2_next;
            den_reg <= den_next;
            ds_reg  <= ds_next;
        end
    end

    qlrs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v4_reg),
        .n1       (n1_reg),
        .n2       (n2_reg),
        .den      (den_reg),
        .side_in  (ds_reg),
        .out_vld  (d_vld),
        .q1       (dq[0]),
        .q2       (dq[1]),
        .r1       (dr[0]),
        .r2       (dr[1]),
        .den_out  (d_den),
        .side_out (d_side)
    );

    // round half away from zero, then clip to the signed word range
    always_comb
    begin
        logic          up;
        logic          neg;
        logic [QW:0]   qr;
        logic [QW:0]   lim;
        logic [W-1:0]  mag;
        logic [1:0]    sat_l;
        for (int l = 0; l < 2; l++)
        begin
            neg   = (l == 0) ? d_side.neg1 : d_side.neg2;
            up    = ({dr[l], 1'b0} >= {1'b0, d_den});
            qr    = (QW+1)'(dq[l]) + (QW+1)'(up);
            lim   = (QW+1)'(neg ? qlrs_pkg::HALF_MAG : qlrs_pkg::MAX_POS);
            sat_l[l] = (qr > lim);
            mag   = sat_l[l] ? lim[W-1:0] : qr[W-1:0];
            root_next[l] = !d_side.go ? '0 : (neg ? (~mag + 1'b1) : mag);
        end
        sat_next = d_side.go && (sat_l[0] || sat_l[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= d_side.status;
            root1_reg  <= root_next[0];
            root2_reg  <= root_next[1];
            sat_reg    <= sat_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_status = status_reg;
    assign first_root  = root1_reg;
    assign second_root = root2_reg;
    assign saturated   = sat_reg;

endmodule

/* hdl/qlrs_chk.sv */
// qlrs_chk: port-level checks on the root solver, bound to the top level.
// Depends on qlrs_pkg and quadratic_linear_root_solver.
module qlrs_chk
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [2:0]                    root_status,
    input logic signed [qlrs_pkg::W-1:0] first_root,
    input logic signed [qlrs_pkg::W-1:0] second_root,
    input logic                          saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_root) &&
        $stable(second_root) && $stable(root_status))
        else $error("stalled result word changed");

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_status != qlrs_pkg::ST_ONE) &&
        (root_status != qlrs_pkg::ST_TWO) |->
        first_root == '0 && second_root == '0 && !saturated)
        else $error("rootless word carries root data");

    a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_status == qlrs_pkg::ST_ONE |-> first_root == second_root)
        else $error("single root differs between outputs");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> root_status <= qlrs_pkg::ST_NOTQ)
        else $error("status code out of range");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready not tied to output drain");

endmodule

bind quadratic_linear_root_solver qlrs_chk u_qlrs_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .root_status (root_status),
    .first_root  (first_root),
    .second_root (second_root),
    .saturated   (saturated)
);
